// ----- src/bftm_pkg.sv -----
// ----------------------------------------------------------------------------
// bftm_pkg
// Shared constants, widths and character codes of the tape machine.
// ----------------------------------------------------------------------------
`default_nettype none

package bftm_pkg;

  localparam int TAPE_CELLS    = 32768;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int NEST_DEPTH    = 64;

  localparam int TA_W = (TAPE_CELLS < 2) ? 1 : $clog2(TAPE_CELLS);
  localparam int PA_W = $clog2(PROGRAM_DEPTH);
  localparam int PL_W = $clog2(PROGRAM_DEPTH + 1);
  localparam int SA_W = (NEST_DEPTH < 2) ? 1 : $clog2(NEST_DEPTH);
  localparam int SD_W = $clog2(NEST_DEPTH + 1);

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HALTED   = 3'd1;
  localparam logic [2:0] ST_UNCLOSED = 3'd2;
  localparam logic [2:0] ST_UNEXP    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DEEP     = 3'd5;

  localparam logic [7:0] CH_RIGHT   = 8'h3E;
  localparam logic [7:0] CH_LEFT    = 8'h3C;
  localparam logic [7:0] CH_INC     = 8'h2B;
  localparam logic [7:0] CH_DEC     = 8'h2D;
  localparam logic [7:0] CH_OUT     = 8'h2E;
  localparam logic [7:0] CH_IN      = 8'h2C;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

endpackage

`default_nettype wire

// ----- src/bftm_if.sv -----
// ----------------------------------------------------------------------------
// bftm_if
// Valid/ready channels for command words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface bftm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] program_byte;
  logic [7:0] input_byte;

  modport source (output valid, action, program_byte, input_byte, input ready);
  modport sink   (input valid, action, program_byte, input_byte, output ready);
endinterface

interface bftm_rsp_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [2:0]  status;
  logic [15:0] error_line;
  logic [15:0] error_column;
  logic [7:0]  cell_value;

  modport source (output valid, out_valid, out_byte, status, error_line, error_column,
                  cell_value, input ready);
  modport sink   (input valid, out_valid, out_byte, status, error_line, error_column,
                  cell_value, output ready);
endinterface

`default_nettype wire

// ----- src/bftm_ram.sv -----
// ----------------------------------------------------------------------------
// bftm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bftm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH < 2) ? 1 : $clog2(DEPTH))-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH < 2) ? 1 : $clog2(DEPTH))-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/brainfuck_tape_machine_core.sv -----
// ----------------------------------------------------------------------------
// brainfuck_tape_machine_core
// Program store, jump table, tape and bracket stack in RAMs, with a sequencer.
// ----------------------------------------------------------------------------
// Step: S_FETCH then S_RESP; '>' and '<' add S_TWAIT, S_TLOAD (tape re-read).
// Load: a matched ']' adds S_JMP1, S_JMP2 (two jump table writes, one port).
// Clear: the tape write port sweeps every cell to zero, then responds.
// Reset runs the same sweep with cmd.ready held low.
// Throughput is one word at a time; the single tape port sets the clear cost.
`default_nettype none

module brainfuck_tape_machine_core (
  input  wire logic clk,
  input  wire logic rst,
  bftm_cmd_if.sink   cmd,
  bftm_rsp_if.source rsp
);
  import bftm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_TWAIT, S_TLOAD, S_JMP1, S_JMP2, S_RESP
  } state_t;

  state_t          state;
  logic [TA_W-1:0] clr_cnt;
  logic            clr_resp;
  logic [SD_W-1:0] stack_depth;
  logic [PL_W-1:0] prog_len;
  logic [PL_W-1:0] pc;
  logic [TA_W-1:0] cell_ptr;
  logic [7:0]      cur_cell;
  logic [15:0]     line_cnt;
  logic [15:0]     col_cnt;
  logic [2:0]      err_code;
  logic [15:0]     err_line;
  logic [15:0]     err_col;
  logic            halted;
  logic            emit;
  logic [7:0]      emit_byte;
  logic [PA_W-1:0] here_addr;
  logic [PA_W-1:0] open_addr;

  // Input byte is captured at accept for use in the execute cycle.
  logic [7:0]      cmd_in_byte;

  logic            cmd_acc;
  logic [7:0]      prog_rdata;
  logic [PA_W-1:0] jt_rdata;
  logic [PA_W-1:0] stk_rdata;
  logic [7:0]      tape_rdata;

  logic            prog_we;
  logic            jt_we;
  logic [PA_W-1:0] jt_waddr;
  logic [PA_W-1:0] jt_wdata;
  logic            stk_we;
  logic            tape_we;
  logic [TA_W-1:0] tape_waddr;
  logic [7:0]      tape_wdata;
  logic [7:0]      cell_next;
  logic            exec_we;
  logic            pop_go;
  logic            take_jump;
  logic            rsp_load;

  assign cmd_acc   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    cell_next = cur_cell;
    exec_we   = 1'b0;
    case (prog_rdata)
      CH_INC: begin
        cell_next = cur_cell + 8'd1;
        exec_we   = 1'b1;
      end
      CH_DEC: begin
        cell_next = cur_cell - 8'd1;
        exec_we   = 1'b1;
      end
      CH_IN: begin
        cell_next = cmd_in_byte;
        exec_we   = 1'b1;
      end
      default: ;
    endcase
  end

  assign prog_we    = cmd_acc && (cmd.action == ACT_LOAD) &&
                      (prog_len < PL_W'(PROGRAM_DEPTH));
  assign stk_we     = prog_we && (cmd.program_byte == CH_OPEN) &&
                      (stack_depth < SD_W'(NEST_DEPTH));
  assign pop_go     = prog_we && (cmd.program_byte == CH_CLOSE) && (stack_depth != '0);
  assign take_jump  = ((prog_rdata == CH_OPEN) && (cur_cell == 8'd0)) ||
                      ((prog_rdata == CH_CLOSE) && (cur_cell != 8'd0));
  assign rsp_load   = (state == S_RESP) && (!rsp.valid || rsp.ready);
  assign jt_we      = (state == S_JMP1) || (state == S_JMP2);
  assign jt_waddr   = (state == S_JMP1) ? stk_rdata : here_addr;
  assign jt_wdata   = (state == S_JMP1) ? here_addr : open_addr;
  assign tape_we    = (state == S_CLEAR) || ((state == S_FETCH) && exec_we);
  assign tape_waddr = (state == S_CLEAR) ? clr_cnt : cell_ptr;
  assign tape_wdata = (state == S_CLEAR) ? 8'd0 : cell_next;

  bftm_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk(clk), .we(prog_we), .waddr(prog_len[PA_W-1:0]), .wdata(cmd.program_byte),
    .raddr(pc[PA_W-1:0]), .rdata(prog_rdata)
  );

  bftm_ram #(.WIDTH(PA_W), .DEPTH(PROGRAM_DEPTH)) u_jump (
    .clk(clk), .we(jt_we), .waddr(jt_waddr), .wdata(jt_wdata),
    .raddr(pc[PA_W-1:0]), .rdata(jt_rdata)
  );

  bftm_ram #(.WIDTH(PA_W), .DEPTH(NEST_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stack_depth[SA_W-1:0]),
    .wdata(prog_len[PA_W-1:0]),
    .raddr(SA_W'(stack_depth - SD_W'(1))), .rdata(stk_rdata)
  );

  bftm_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
    .clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
    .raddr(cell_ptr), .rdata(tape_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      clr_resp    <= 1'b0;
      stack_depth <= '0;
      prog_len    <= '0;
      pc          <= '0;
      cell_ptr    <= '0;
      cur_cell    <= 8'd0;
      line_cnt    <= 16'd0;
      col_cnt     <= 16'd0;
      err_code    <= ST_OK;
      err_line    <= 16'd0;
      err_col     <= 16'd0;
      halted      <= 1'b0;
      emit        <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + TA_W'(1);
          if (clr_cnt == TA_W'(TAPE_CELLS - 1)) begin
            state <= clr_resp ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_acc) begin
            halted      <= (cmd.action == ACT_STEP) && (err_code == ST_OK) &&
                           (stack_depth == '0) && (pc >= prog_len);
            emit        <= 1'b0;
            emit_byte   <= 8'd0;
            cmd_in_byte <= cmd.input_byte;
            case (cmd.action)
              ACT_CLEAR: begin
                stack_depth <= '0;
                prog_len    <= '0;
                pc          <= '0;
                cell_ptr    <= '0;
                cur_cell    <= 8'd0;
                line_cnt    <= 16'd0;
                col_cnt     <= 16'd0;
                err_code    <= ST_OK;
                err_line    <= 16'd0;
                err_col     <= 16'd0;
                clr_cnt     <= '0;
                clr_resp    <= 1'b1;
                state       <= S_CLEAR;
              end
              ACT_LOAD: begin
                // pop; stack read of the old top lands next cycle
                state <= pop_go ? S_JMP1 : S_RESP;
                if (!prog_we) begin
                  if (err_code == ST_OK) begin
                    err_code <= ST_FULL;
                    err_line <= line_cnt;
                    err_col  <= col_cnt;
                  end
                end else begin
                  here_addr <= prog_len[PA_W-1:0];
                  prog_len  <= prog_len + PL_W'(1);
                  if (cmd.program_byte == CH_OPEN) begin
                    if (stk_we) begin
                      stack_depth <= stack_depth + SD_W'(1);
                    end else if (err_code == ST_OK) begin
                      err_code <= ST_DEEP;
                      err_line <= line_cnt;
                      err_col  <= col_cnt;
                    end
                  end else if (cmd.program_byte == CH_CLOSE) begin
                    if (stack_depth == '0) begin
                      if (err_code == ST_OK) begin
                        err_code <= ST_UNEXP;
                        err_line <= line_cnt;
                        err_col  <= col_cnt;
                      end
                    end else begin
                      stack_depth <= stack_depth - SD_W'(1);
                    end
                  end
                end
                if (cmd.program_byte == CH_NEWLINE) begin
                  if (line_cnt != 16'hFFFF) begin
                    line_cnt <= line_cnt + 16'd1;
                  end
                  col_cnt <= 16'd0;
                end else if (col_cnt != 16'hFFFF) begin
                  col_cnt <= col_cnt + 16'd1;
                end
              end
              ACT_STEP: begin
                if (err_code == ST_OK && stack_depth == '0 && pc < prog_len) begin
                  state <= S_FETCH;
                end else begin
                  state <= S_RESP;
                end
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_FETCH: begin
          pc    <= take_jump ? PL_W'(jt_rdata) + PL_W'(1) : pc + PL_W'(1);
          state <= ((prog_rdata == CH_RIGHT) || (prog_rdata == CH_LEFT)) ? S_TWAIT : S_RESP;
          if (exec_we) begin
            cur_cell <= cell_next;
          end
          case (prog_rdata)
            CH_RIGHT: begin
              cell_ptr <= (cell_ptr == TA_W'(TAPE_CELLS - 1)) ? '0 : cell_ptr + TA_W'(1);
            end
            CH_LEFT: begin
              cell_ptr <= (cell_ptr == '0) ? TA_W'(TAPE_CELLS - 1) : cell_ptr - TA_W'(1);
            end
            CH_OUT: begin
              emit      <= 1'b1;
              emit_byte <= cur_cell;
            end
            default: ;
          endcase
        end
        S_TWAIT: begin
          state <= S_TLOAD;
        end
        S_TLOAD: begin
          cur_cell <= tape_rdata;
          state    <= S_RESP;
        end
        S_JMP1: begin
          open_addr <= stk_rdata;
          state     <= S_JMP2;
        end
        S_JMP2: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp.out_valid  <= emit;
            rsp.out_byte   <= emit_byte;
            rsp.cell_value <= cur_cell;
            clr_resp       <= 1'b0;
            if (err_code != ST_OK) begin
              rsp.status       <= err_code;
              rsp.error_line   <= err_line;
              rsp.error_column <= err_col;
            end else if (stack_depth != '0) begin
              rsp.status       <= ST_UNCLOSED;
              rsp.error_line   <= line_cnt;
              rsp.error_column <= col_cnt;
            end else begin
              rsp.status       <= halted ? ST_HALTED : ST_OK;
              rsp.error_line   <= 16'd0;
              rsp.error_column <= 16'd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= SD_W'(NEST_DEPTH))
    else $error("bracket stack overflow");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    prog_len <= PL_W'(PROGRAM_DEPTH))
    else $error("program length past depth");

  a_exec_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (pc < prog_len && err_code == ST_OK && stack_depth == '0))
    else $error("executing outside a valid program");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    cell_ptr <= TA_W'(TAPE_CELLS - 1))
    else $error("tape pointer out of range");

  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state == S_RESP || state == S_TWAIT))
    else $error("execute cycle did not advance");

endmodule

`default_nettype wire
